// ----- rtl/tbm_pkg.sv -----
package tbm_pkg;

	localparam int COORD_W = 8;
	localparam int SIZE_W  = 9;
	localparam int REACH_W = 11;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_TORUS_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TORUS_HEIGHT = 2'd1;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd16;

	// load enables for the four pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} adv_t;

	// four restoring remainder steps, most significant bit first
	function automatic logic [SIZE_W-1:0] mod_part(input logic [SIZE_W-1:0] r,
			input logic [3:0] nib, input logic [SIZE_W-1:0] n);
		logic [SIZE_W:0] t;
		logic [SIZE_W-1:0] acc;
		acc = r;
		for (int i = 3; i >= 0; i--) begin
			t = {acc, nib[i]};
			if (t >= {1'b0, n})
				t = t - {1'b0, n};
			acc = t[SIZE_W-1:0];
		end
		return acc;
	endfunction

	// forward ring distance of two already reduced coordinates
	function automatic logic [SIZE_W-1:0] ring_dist(input logic [SIZE_W-1:0] s,
			input logic [SIZE_W-1:0] e, input logic [SIZE_W-1:0] n);
		logic [SIZE_W:0] t;
		if (e >= s)
			t = {1'b0, e} - {1'b0, s};
		else
			t = {1'b0, e} + {1'b0, n} - {1'b0, s};
		return t[SIZE_W-1:0];
	endfunction

endpackage

// ----- rtl/torus_box_merge.sv -----
// Each merge passes register stages 1 to 4 in order and is shown on out_valid from stage 4; out_stall holds it.
// Throughput: one merge per cycle unless in_stall is high; four register stages, the remainder by ring size
// split as four bits in stage 1 and four in stage 2.
// in_stall rises only when all four stages hold items and the output is stalled.
// Reset (arst_n low, asynchronous) empties the pipeline and sets both ring sizes to 16.
module torus_box_merge #(
	parameter int MAX_SIDE = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tbm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tbm_pkg::SIZE_W-1:0]          cfg_data,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [tbm_pkg::COORD_W-1:0]         a_left,
	input  logic [tbm_pkg::COORD_W-1:0]         a_right,
	input  logic [tbm_pkg::COORD_W-1:0]         a_bottom,
	input  logic [tbm_pkg::COORD_W-1:0]         a_top,
	input  logic                                a_odd,
	input  logic                                a_cross_vert,
	input  logic                                a_cross_hori,
	input  logic [tbm_pkg::COORD_W-1:0]         b_left,
	input  logic [tbm_pkg::COORD_W-1:0]         b_right,
	input  logic [tbm_pkg::COORD_W-1:0]         b_bottom,
	input  logic [tbm_pkg::COORD_W-1:0]         b_top,
	input  logic                                b_odd,

	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [tbm_pkg::COORD_W-1:0]         m_left,
	output logic [tbm_pkg::COORD_W-1:0]         m_right,
	output logic [tbm_pkg::COORD_W-1:0]         m_bottom,
	output logic [tbm_pkg::COORD_W-1:0]         m_top,
	output logic                                m_odd,
	output logic                                m_cross_vert,
	output logic                                m_cross_hori,
	output logic                                fits_half
);

	localparam int SW = tbm_pkg::SIZE_W;

	// ring sizes are stored already clamped to 1..MAX_SIDE
	function automatic logic [SW-1:0] eff_size(input logic [SW-1:0] v);
		if (v == '0)
			return SW'(1);
		else if (32'(v) > MAX_SIDE)
			return SW'(MAX_SIDE);
		else
			return v;
	endfunction

	logic [SW-1:0] width_q, height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= tbm_pkg::SIZE_RESET;
			height_q <= tbm_pkg::SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tbm_pkg::REG_TORUS_WIDTH:  width_q  <= eff_size(cfg_data);
				tbm_pkg::REG_TORUS_HEIGHT: height_q <= eff_size(cfg_data);
				default: ;
			endcase
		end
	end

	// pipeline control: a stage loads when it is empty or the next one moves
	logic          valid_s1, valid_s2, valid_s3, valid_s4;
	logic          rdy1, rdy2, rdy3, rdy4;
	tbm_pkg::adv_t adv;

	assign rdy4 = !valid_s4 || !out_stall;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;

	assign adv.s1 = rdy1;
	assign adv.s2 = rdy2;
	assign adv.s3 = rdy3;
	assign adv.s4 = rdy4;

	assign in_stall  = !rdy1;
	assign out_valid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	// parity and prior flags ride along with the axis stages
	logic odd_s1, odd_s2, odd_s3, odd_s4;
	logic cv_s1, cv_s2, cv_s3, cv_s4;
	logic ch_s1, ch_s2, ch_s3, ch_s4;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			odd_s1 <= a_odd ^ b_odd;
			cv_s1  <= a_cross_vert;
			ch_s1  <= a_cross_hori;
		end
		if (rdy2) begin
			odd_s2 <= odd_s1;
			cv_s2  <= cv_s1;
			ch_s2  <= ch_s1;
		end
		if (rdy3) begin
			odd_s3 <= odd_s2;
			cv_s3  <= cv_s2;
			ch_s3  <= ch_s2;
		end
		if (rdy4) begin
			odd_s4 <= odd_s3;
			cv_s4  <= cv_s3;
			ch_s4  <= ch_s3;
		end
	end

	logic h_fits, h_wraps, h_zero;
	logic v_fits, v_wraps, v_zero;

	tbm_axis u_hori (
		.clk        (clk),
		.adv        (adv),
		.n          (width_q),
		.ts         (a_left),
		.te         (a_right),
		.os         (b_left),
		.oe         (b_right),
		.mstart     (m_left),
		.mstop      (m_right),
		.fits       (h_fits),
		.wraps      (h_wraps),
		.start_zero (h_zero)
	);

	tbm_axis u_vert (
		.clk        (clk),
		.adv        (adv),
		.n          (height_q),
		.ts         (a_bottom),
		.te         (a_top),
		.os         (b_bottom),
		.oe         (b_top),
		.mstart     (m_bottom),
		.mstop      (m_top),
		.fits       (v_fits),
		.wraps      (v_wraps),
		.start_zero (v_zero)
	);

	// horizontal start at zero carries no meaning for the flags
	logic unused_h_zero;
	assign unused_h_zero = h_zero;

	assign m_odd        = odd_s4;
	assign m_cross_vert = cv_s4 | h_wraps;
	assign m_cross_hori = ch_s4 | v_zero | v_wraps;
	assign fits_half    = h_fits & v_fits & (unused_h_zero | !unused_h_zero);

	// input only backs up when every stage is occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4))
		else $error("input stalled with a bubble in the pipeline");

	a_no_stall_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output drains");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !out_stall) |=> out_valid)
		else $error("item in stage 3 did not reach the output");

	a_point_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && m_left == m_right && m_bottom == m_top) |-> fits_half)
		else $error("zero-span box reported as too large");

endmodule

// ----- rtl/tbm_axis.sv -----
module tbm_axis (
	input  logic                          clk,
	input  tbm_pkg::adv_t                 adv,
	input  logic [tbm_pkg::SIZE_W-1:0]    n,
	input  logic [tbm_pkg::COORD_W-1:0]   ts,
	input  logic [tbm_pkg::COORD_W-1:0]   te,
	input  logic [tbm_pkg::COORD_W-1:0]   os,
	input  logic [tbm_pkg::COORD_W-1:0]   oe,
	output logic [tbm_pkg::COORD_W-1:0]   mstart,
	output logic [tbm_pkg::COORD_W-1:0]   mstop,
	output logic                          fits,
	output logic                          wraps,
	output logic                          start_zero
);

	localparam int CW = tbm_pkg::COORD_W;
	localparam int SW = tbm_pkg::SIZE_W;
	localparam int RW = tbm_pkg::REACH_W;

	// stage 1: order by start, upper half of the remainders
	logic          swap;
	logic [CW-1:0] as_c, ae_c, bs_c, be_c;
	logic [CW-1:0] as_s1, ae_s1, bs_s1, be_s1;
	logic [SW-1:0] ras_s1, rae_s1, rbs_s1, rbe_s1;

	assign swap = !(ts < os);
	assign as_c = swap ? os : ts;
	assign ae_c = swap ? oe : te;
	assign bs_c = swap ? ts : os;
	assign be_c = swap ? te : oe;

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			as_s1  <= as_c;
			ae_s1  <= ae_c;
			bs_s1  <= bs_c;
			be_s1  <= be_c;
			ras_s1 <= tbm_pkg::mod_part('0, as_c[CW-1:CW-4], n);
			rae_s1 <= tbm_pkg::mod_part('0, ae_c[CW-1:CW-4], n);
			rbs_s1 <= tbm_pkg::mod_part('0, bs_c[CW-1:CW-4], n);
			rbe_s1 <= tbm_pkg::mod_part('0, be_c[CW-1:CW-4], n);
		end
	end

	// stage 2: finish remainders, classify overlap, pick the further-right end
	logic [RW-1:0] reach_a, reach_b;
	logic          be_wraps;
	logic          ovl_b, ovl_a;
	logic [CW-1:0] as_s2, ae_s2, bs_s2, be_s2;
	logic [SW-1:0] mas_s2, mae_s2, mbs_s2, mbe_s2;
	logic          ovl_s2, ovl_b_s2, rr_a_s2;

	assign be_wraps = be_s1 < bs_s1;
	assign ovl_b    = !(as_s1 > be_s1) && be_wraps;
	assign ovl_a    = !(ae_s1 < bs_s1) || (ae_s1 < as_s1);
	assign reach_a  = RW'(ae_s1)
		+ ((ae_s1 < as_s1) ? RW'(n) : RW'(0))
		+ ((be_wraps && !(as_s1 > be_s1)) ? RW'(n) : RW'(0));
	assign reach_b  = RW'(be_s1) + (be_wraps ? RW'(n) : RW'(0));

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			as_s2    <= as_s1;
			ae_s2    <= ae_s1;
			bs_s2    <= bs_s1;
			be_s2    <= be_s1;
			mas_s2   <= tbm_pkg::mod_part(ras_s1, as_s1[3:0], n);
			mae_s2   <= tbm_pkg::mod_part(rae_s1, ae_s1[3:0], n);
			mbs_s2   <= tbm_pkg::mod_part(rbs_s1, bs_s1[3:0], n);
			mbe_s2   <= tbm_pkg::mod_part(rbe_s1, be_s1[3:0], n);
			ovl_s2   <= ovl_b || ovl_a;
			ovl_b_s2 <= ovl_b;
			rr_a_s2  <= reach_a > reach_b;
		end
	end

	// stage 3: pick the merged ends; the disjoint case keeps the shorter covering span
	logic [SW-1:0] d_ab, d_ba;
	logic          start_b, stop_a;
	logic [CW-1:0] ms_s3, me_s3;
	logic [SW-1:0] mms_s3, mme_s3;

	assign d_ab = tbm_pkg::ring_dist(mas_s2, mbe_s2, n);
	assign d_ba = tbm_pkg::ring_dist(mbs_s2, mae_s2, n);

	always_comb begin
		if (ovl_s2) begin
			start_b = ovl_b_s2;
			stop_a  = rr_a_s2;
		end else begin
			start_b = d_ab > d_ba;
			stop_a  = d_ab > d_ba;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			ms_s3  <= start_b ? bs_s2 : as_s2;
			mms_s3 <= start_b ? mbs_s2 : mas_s2;
			me_s3  <= stop_a ? ae_s2 : be_s2;
			mme_s3 <= stop_a ? mae_s2 : mbe_s2;
		end
	end

	// stage 4: span check and flags
	logic [SW-1:0] span;
	logic [CW-1:0] ms_s4, me_s4;
	logic          fits_s4, wraps_s4, zero_s4;

	assign span = tbm_pkg::ring_dist(mms_s3, mme_s3, n);

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			ms_s4    <= ms_s3;
			me_s4    <= me_s3;
			fits_s4  <= span <= (n >> 1);
			wraps_s4 <= me_s3 < ms_s3;
			zero_s4  <= ms_s3 == '0;
		end
	end

	assign mstart     = ms_s4;
	assign mstop      = me_s4;
	assign fits       = fits_s4;
	assign wraps      = wraps_s4;
	assign start_zero = zero_s4;

endmodule

// ----- verif/tb_torus_box_merge.sv -----
`timescale 1ns / 100ps

module tb_torus_box_merge;

	localparam int COORD_W   = tbm_pkg::COORD_W;
	localparam int SIZE_W    = tbm_pkg::SIZE_W;
	localparam int CFG_IDX_W = tbm_pkg::CFG_IDX_W;

	localparam int MAX_SIDE       = 256;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 12;
	localparam int PHASE_ITEMS    = 90;

	// indexes that map to no register; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_3 = 2'd3;

	typedef struct packed {
		logic [COORD_W-1:0] a_left;
		logic [COORD_W-1:0] a_right;
		logic [COORD_W-1:0] a_bottom;
		logic [COORD_W-1:0] a_top;
		logic               a_odd;
		logic               a_cross_vert;
		logic               a_cross_hori;
		logic [COORD_W-1:0] b_left;
		logic [COORD_W-1:0] b_right;
		logic [COORD_W-1:0] b_bottom;
		logic [COORD_W-1:0] b_top;
		logic               b_odd;
	} box_pair_t;

	typedef struct packed {
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] right;
		logic [COORD_W-1:0] bottom;
		logic [COORD_W-1:0] top;
		logic               odd;
		logic               cross_vert;
		logic               cross_hori;
		logic               fits_half;
	} merged_box_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SIZE_W-1:0]    cfg_data  = '0;

	logic               in_valid     = 1'b0;
	logic               in_stall;
	logic [COORD_W-1:0] a_left       = '0;
	logic [COORD_W-1:0] a_right      = '0;
	logic [COORD_W-1:0] a_bottom     = '0;
	logic [COORD_W-1:0] a_top        = '0;
	logic               a_odd        = 1'b0;
	logic               a_cross_vert = 1'b0;
	logic               a_cross_hori = 1'b0;
	logic [COORD_W-1:0] b_left       = '0;
	logic [COORD_W-1:0] b_right      = '0;
	logic [COORD_W-1:0] b_bottom     = '0;
	logic [COORD_W-1:0] b_top        = '0;
	logic               b_odd        = 1'b0;

	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [COORD_W-1:0] m_left;
	logic [COORD_W-1:0] m_right;
	logic [COORD_W-1:0] m_bottom;
	logic [COORD_W-1:0] m_top;
	logic               m_odd;
	logic               m_cross_vert;
	logic               m_cross_hori;
	logic               fits_half;

	// shadow of the ring size registers
	logic [SIZE_W-1:0] ring_width  = tbm_pkg::SIZE_RESET;
	logic [SIZE_W-1:0] ring_height = tbm_pkg::SIZE_RESET;

	merged_box_t merged_q[$];
	int errors      = 0;
	int n_sent      = 0;
	int n_merged    = 0;
	int n_cfg       = 0;
	int idle_cycles = 0;
	int rx_hold     = 0;
	bit quiet       = 1'b0;

	torus_box_merge #(
		.MAX_SIDE(MAX_SIDE)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.a_left(a_left),
		.a_right(a_right),
		.a_bottom(a_bottom),
		.a_top(a_top),
		.a_odd(a_odd),
		.a_cross_vert(a_cross_vert),
		.a_cross_hori(a_cross_hori),
		.b_left(b_left),
		.b_right(b_right),
		.b_bottom(b_bottom),
		.b_top(b_top),
		.b_odd(b_odd),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.m_left(m_left),
		.m_right(m_right),
		.m_bottom(m_bottom),
		.m_top(m_top),
		.m_odd(m_odd),
		.m_cross_vert(m_cross_vert),
		.m_cross_hori(m_cross_hori),
		.fits_half(fits_half)
	);

	always #4 clk = ~clk;

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ---------------- merge predictor ----------------

	function automatic int ring_size(input logic [SIZE_W-1:0] n);
		if (n == 0)
			return 1;
		if (n > MAX_SIDE)
			return MAX_SIDE;
		return int'(n);
	endfunction

	function automatic int fwd_dist(input int s, input int e, input int n);
		int d;
		d = (e - s) % n;
		if (d < 0)
			d += n;
		return d;
	endfunction

	// end that reaches further clockwise, with wrapped ends unrolled by n
	function automatic int far_end(input int lo_s, input int lo_e, input int hi_s,
			input int hi_e, input int n);
		int ra;
		int rb;
		ra = lo_e;
		rb = hi_e;
		if (lo_e < lo_s)
			ra += n;
		if (hi_e < hi_s) begin
			rb += n;
			if (!(lo_s > hi_e))
				ra += n;
		end
		return (ra > rb) ? lo_e : hi_e;
	endfunction

	function automatic void merge_ring(input int ts, input int te, input int os,
			input int oe, input int n, output int ms, output int me);
		int lo_s;
		int lo_e;
		int hi_s;
		int hi_e;
		// on a tie the second box goes first
		if (ts < os) begin
			lo_s = ts; lo_e = te; hi_s = os; hi_e = oe;
		end else begin
			lo_s = os; lo_e = oe; hi_s = ts; hi_e = te;
		end
		if (!(lo_s > hi_e) && (hi_e < hi_s)) begin
			ms = hi_s;
			me = far_end(lo_s, lo_e, hi_s, hi_e, n);
		end else if (!(lo_e < hi_s) || (lo_e < lo_s)) begin
			ms = lo_s;
			me = far_end(lo_s, lo_e, hi_s, hi_e, n);
		end else if (fwd_dist(lo_s, hi_e, n) > fwd_dist(hi_s, lo_e, n)) begin
			ms = hi_s;
			me = lo_e;
		end else begin
			ms = lo_s;
			me = hi_e;
		end
	endfunction

	function automatic merged_box_t predict_merge(input box_pair_t p);
		int w;
		int h;
		int l;
		int r;
		int bt;
		int tp;
		merged_box_t m;
		w = ring_size(ring_width);
		h = ring_size(ring_height);
		merge_ring(p.a_left, p.a_right, p.b_left, p.b_right, w, l, r);
		merge_ring(p.a_bottom, p.a_top, p.b_bottom, p.b_top, h, bt, tp);
		m.left       = COORD_W'(l);
		m.right      = COORD_W'(r);
		m.bottom     = COORD_W'(bt);
		m.top        = COORD_W'(tp);
		m.odd        = p.a_odd ^ p.b_odd;
		m.cross_vert = p.a_cross_vert | (r < l);
		m.cross_hori = p.a_cross_hori | (bt == 0) | (tp < bt);
		m.fits_half  = !(fwd_dist(l, r, w) > w / 2 || fwd_dist(bt, tp, h) > h / 2);
		return m;
	endfunction

	// ---------------- idling ----------------

	function automatic int gap_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// ---------------- result side ----------------

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_side
		merged_box_t got;
		merged_box_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {m_left, m_right, m_bottom, m_top, m_odd, m_cross_vert, m_cross_hori,
				fits_half};
			if (merged_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected merge result, expected none got %h", $time, got);
			end else begin
				want = merged_q.pop_front();
				n_merged++;
				check_field("m_left", want.left, got.left);
				check_field("m_right", want.right, got.right);
				check_field("m_bottom", want.bottom, got.bottom);
				check_field("m_top", want.top, got.top);
				check_field("m_odd", want.odd, got.odd);
				check_field("m_cross_vert", want.cross_vert, got.cross_vert);
				check_field("m_cross_hori", want.cross_hori, got.cross_hori);
				check_field("fits_half", want.fits_half, got.fits_half);
			end
		end
		if (rx_hold > 0) begin
			out_stall <= 1'b1;
			rx_hold--;
		end else begin
			out_stall <= 1'b0;
			if (!quiet && $urandom_range(0, 99) < 20)
				rx_hold = gap_len();
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ---------------- stimulus side ----------------

	task automatic send_pair(input box_pair_t p);
		int gap;
		in_valid     <= 1'b1;
		a_left       <= p.a_left;
		a_right      <= p.a_right;
		a_bottom     <= p.a_bottom;
		a_top        <= p.a_top;
		a_odd        <= p.a_odd;
		a_cross_vert <= p.a_cross_vert;
		a_cross_hori <= p.a_cross_hori;
		b_left       <= p.b_left;
		b_right      <= p.b_right;
		b_bottom     <= p.b_bottom;
		b_top        <= p.b_top;
		b_odd        <= p.b_odd;
		do @(posedge clk); while (in_stall);
		merged_q.push_back(predict_merge(p));
		n_sent++;
		if (!quiet && $urandom_range(0, 99) < 30) begin
			gap = gap_len();
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		if (in_valid)
			in_valid <= 1'b0;
		while (merged_q.size() != 0)
			@(posedge clk);
	endtask

	// leaves cfg_valid high so back-to-back writes need no extra step
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		n_cfg++;
		case (idx)
			tbm_pkg::REG_TORUS_WIDTH: ring_width = data;
			tbm_pkg::REG_TORUS_HEIGHT: ring_height = data;
			default: ;
		endcase
	endtask

	task automatic set_sizes(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
		wait_idle();
		write_reg(tbm_pkg::REG_TORUS_WIDTH, w);
		write_reg(tbm_pkg::REG_TORUS_HEIGHT, h);
		cfg_valid <= 1'b0;
	endtask

	function automatic box_pair_t mk(input int al, input int ar, input int ab, input int at,
			input bit ao, input bit acv, input bit ach, input int bl, input int br,
			input int bb, input int bt, input bit bo);
		box_pair_t p;
		p.a_left       = COORD_W'(al);
		p.a_right      = COORD_W'(ar);
		p.a_bottom     = COORD_W'(ab);
		p.a_top        = COORD_W'(at);
		p.a_odd        = ao;
		p.a_cross_vert = acv;
		p.a_cross_hori = ach;
		p.b_left       = COORD_W'(bl);
		p.b_right      = COORD_W'(br);
		p.b_bottom     = COORD_W'(bb);
		p.b_top        = COORD_W'(bt);
		p.b_odd        = bo;
		return p;
	endfunction

	// mostly coordinates on the ring, often close together so the
	// overlap and wrap branches see traffic; the rest is full-range noise
	function automatic box_pair_t rand_pair();
		box_pair_t p;
		logic [95:0] noise;
		int w;
		int h;
		int mode;
		w = ring_size(ring_width);
		h = ring_size(ring_height);
		noise = {$urandom, $urandom, $urandom};
		p = noise[$bits(box_pair_t)-1:0];
		mode = $urandom_range(0, 9);
		if (mode < 8) begin
			p.a_left   = COORD_W'($urandom_range(0, w - 1));
			p.a_right  = COORD_W'($urandom_range(0, w - 1));
			p.b_left   = COORD_W'($urandom_range(0, w - 1));
			p.b_right  = COORD_W'($urandom_range(0, w - 1));
			p.a_bottom = COORD_W'($urandom_range(0, h - 1));
			p.a_top    = COORD_W'($urandom_range(0, h - 1));
			p.b_bottom = COORD_W'($urandom_range(0, h - 1));
			p.b_top    = COORD_W'($urandom_range(0, h - 1));
			if (mode >= 5) begin
				p.b_left   = COORD_W'((p.a_left + $urandom_range(0, 3)) % w);
				p.b_bottom = COORD_W'((p.a_bottom + $urandom_range(0, 3)) % h);
			end
		end
		return p;
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return SIZE_W'($urandom_range(2, 256));
		if (r == 6)
			return SIZE_W'(2);
		if (r == 7)
			return SIZE_W'(256);
		if (r == 8)
			return SIZE_W'($urandom_range(0, 1));
		return SIZE_W'($urandom_range(257, 511));
	endfunction

	task automatic send_random(input int count);
		repeat (count) send_pair(rand_pair());
	endtask

	// ---------------- tests ----------------

	task automatic test_reset_sizes();
		send_pair(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_pair(mk(2, 5, 3, 6, 1, 0, 0, 4, 9, 1, 4, 0));       // overlap
		send_pair(mk(1, 2, 1, 2, 0, 0, 0, 10, 12, 10, 12, 1));   // disjoint, wrap shorter
		send_pair(mk(1, 3, 2, 4, 1, 0, 0, 5, 6, 6, 8, 1));       // disjoint, direct shorter
		send_pair(mk(14, 2, 13, 1, 0, 1, 0, 1, 5, 3, 4, 0));     // first box wraps
		send_pair(mk(3, 6, 4, 5, 0, 0, 1, 12, 4, 11, 6, 1));     // second box wraps
		send_pair(mk(13, 2, 15, 1, 1, 1, 1, 14, 5, 12, 0, 1));   // both wrap
		send_pair(mk(5, 7, 6, 8, 0, 0, 0, 5, 9, 6, 6, 0));       // equal starts
		send_pair(mk(0, 8, 1, 9, 0, 0, 0, 2, 4, 3, 5, 0));       // exactly half on both axes
		send_pair(mk(200, 255, 17, 100, 1, 0, 0, 3, 130, 255, 40, 1)); // beyond the ring
		send_pair(mk(255, 255, 255, 255, 1, 1, 1, 255, 255, 255, 255, 1));
	endtask

	task automatic test_size_extremes();
		set_sizes(0, 1);
		send_pair(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
		send_pair(mk(3, 1, 7, 2, 1, 0, 0, 2, 9, 1, 4, 0));
		set_sizes(2, 2);
		send_pair(mk(0, 1, 1, 0, 0, 0, 0, 1, 0, 0, 1, 1));
		send_pair(mk(1, 1, 0, 0, 1, 1, 0, 0, 0, 1, 1, 0));
		set_sizes(256, 256);
		send_pair(mk(0, 127, 0, 128, 0, 0, 0, 128, 255, 129, 255, 0));
		send_pair(mk(250, 5, 255, 0, 1, 0, 1, 10, 240, 1, 254, 1));
		set_sizes(511, 257);
		send_pair(mk(10, 200, 100, 30, 0, 0, 0, 220, 5, 90, 99, 1));
		set_sizes(257, 0);
		send_pair(mk(255, 0, 40, 3, 1, 1, 1, 128, 64, 7, 250, 0));
		set_sizes(3, 256);
		send_pair(mk(0, 2, 200, 100, 0, 0, 0, 2, 0, 50, 60, 1));
	endtask

	task automatic test_unmapped_index();
		wait_idle();
		write_reg(REG_UNMAPPED_2, 9'h1ff);
		write_reg(REG_UNMAPPED_3, 9'h000);
		cfg_valid <= 1'b0;
		send_random(30);
	endtask

	task automatic test_random_sizes(input int phases);
		repeat (phases) begin
			set_sizes(pick_size(), pick_size());
			send_random(PHASE_ITEMS);
		end
	endtask

	task automatic test_back_to_back();
		set_sizes(pick_size(), pick_size());
		quiet = 1'b1;
		send_random(PHASE_ITEMS);
		quiet = 1'b0;
	endtask

	task automatic test_drain_pause();
		set_sizes(16, 16);
		send_random(45);
		wait_idle();
		send_random(45);
	endtask

	initial begin
		while (!arst_n)
			@(posedge clk);
		test_reset_sizes();
		test_size_extremes();
		test_unmapped_index();
		test_random_sizes(5);
		test_back_to_back();
		test_drain_pause();
		test_random_sizes(2);
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("merged %0d box pairs, checked %0d results, %0d register transfers",
			n_sent, n_merged, n_cfg);
		$display("ring sizes swept from 0 to 511, wrapped and beyond-ring coordinates included");
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/tbm_pkg.sv
rtl/tbm_axis.sv
rtl/torus_box_merge.sv
verif/tb_torus_box_merge.sv
